>>> rtl/rtmp_pkg.sv
// Shared types, sizes, register codes and colors of the rotated tile map pixel block.
package rtmp_pkg;

	localparam int VIEW_SIZE   = 256;
	localparam int CELL_PIXELS = 64;
	localparam int MARKER_SIZE = 8;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;

	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;

	localparam int CELL_SHIFT = 8 + $clog2(CELL_PIXELS);
	localparam int PROD_W     = 24;
	localparam int SUM_W      = PROD_W + 1;
	localparam int MUL_W      = SUM_W + 17;
	localparam int POS_W      = 28;
	localparam int CIDX_W     = POS_W - CELL_SHIFT;
	localparam int LIM_W      = 7;
	localparam int SCR_W      = 12;

	localparam int VIEW_HALF = VIEW_SIZE / 2;
	localparam int MARK_LO   = VIEW_HALF - MARKER_SIZE / 2;
	localparam int MARK_HI   = VIEW_HALF + MARKER_SIZE / 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	localparam logic [23:0] COLOR_OUT    = 24'h101010;
	localparam logic [23:0] COLOR_WALL   = 24'h696969;
	localparam logic [23:0] COLOR_FLOOR  = 24'hF0F8FF;
	localparam logic [23:0] COLOR_PLAYER = 24'hFF0000;

	localparam logic [15:0]      DIR_X_RESET = 16'd16384;
	localparam logic [15:0]      DIR_Y_RESET = 16'd0;
	localparam logic [15:0]      ZOOM_RESET  = 16'd256;
	localparam logic [LIM_W-1:0] ROWS_RESET  = LIM_W'(64);
	localparam logic [LIM_W-1:0] COLS_RESET  = LIM_W'(64);

	typedef enum logic [2:0] {
		CFG_PLAYER_X,
		CFG_PLAYER_Y,
		CFG_DIR_X,
		CFG_DIR_Y,
		CFG_ZOOM,
		CFG_MAP_ROWS,
		CFG_MAP_COLS
	} cfg_idx_t;

	typedef struct packed {
		logic              req_type;
		logic [5:0]        cell_row;
		logic [5:0]        cell_col;
		logic              cell_wall;
		logic signed [7:0] pixel_x;
		logic signed [7:0] pixel_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  screen_col;
		logic [7:0]  screen_row;
		logic [23:0] color;
	} out_item_t;

	typedef struct packed {
		logic              is_pix;
		logic              in_map;
		logic              player_sq;
		logic              wall;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        screen_col;
		logic [7:0]        screen_row;
	} q_entry_t;

endpackage

>>> rtl/rotated_tile_map_pixel.sv
// Top level of the rotated tile map pixel block: front end, queue and map back end.
// The block accepts one beat per clock while in_ready is high, map writes and pixel
// requests alike, and returns one pixel beat per pixel request in request order; map
// writes produce no beat. A pixel beat passes through three front stages (products,
// rotate sums, zoom multiply), one queue slot, the map memory read and the output
// register. The four-entry queue lets the front end keep taking beats while the
// output is stalled, until the queue fills. Configuration must be written through
// the cfg_we, cfg_addr and cfg_wdata port while the block is idle, which the block
// does not enforce; the map must be written before any cell of it is shown.
module rotated_tile_map_pixel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [23:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  rtmp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rtmp_pkg::out_item_t out_data
);

	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	rtmp_pkg::q_entry_t q_wdata;
	rtmp_pkg::q_entry_t q_rdata;

	rtmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_push   (q_push),
		.q_full   (q_full),
		.q_data   (q_wdata)
	);

	rtmp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.empty    (q_empty)
	);

	rtmp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (q_rdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

>>> rtl/rtmp_fifo.sv
// Short register queue between the transform front end and the map back end.
module rtmp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rtmp_pkg::q_entry_t  push_data,
	output logic                full,
	input  logic                pop,
	output rtmp_pkg::q_entry_t  pop_data,
	output logic                empty
);

	rtmp_pkg::q_entry_t                  slot_q [rtmp_pkg::QUEUE_DEPTH];
	logic [rtmp_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [rtmp_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [rtmp_pkg::QPTR_W:0]           count_q;

	assign full     = (count_q == (rtmp_pkg::QPTR_W + 1)'(rtmp_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/rtmp_front.sv
// Front end: configuration registers, item intake and the rotate, scale and cell classify pipeline.
module rtmp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [23:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  rtmp_pkg::in_item_t  in_data,
	output logic                q_push,
	input  logic                q_full,
	output rtmp_pkg::q_entry_t  q_data
);

	typedef struct packed {
		logic                        ok;
		logic [rtmp_pkg::CIDX_W-1:0] idx;
	} cell_t;

	logic signed [23:0]                 player_x_q;
	logic signed [23:0]                 player_y_q;
	logic signed [15:0]                 dir_x_q;
	logic signed [15:0]                 dir_y_q;
	logic [15:0]                        zoom_q;
	logic [rtmp_pkg::LIM_W-1:0]         map_rows_q;
	logic [rtmp_pkg::LIM_W-1:0]         map_cols_q;

	logic                               en;
	logic                               valid_s1, valid_s2, valid_s3;
	rtmp_pkg::in_item_t                 item_s1, item_s2, item_s3;
	logic signed [rtmp_pkg::PROD_W-1:0] ptx_s1, pty_s1, puy_s1, pux_s1;
	logic signed [rtmp_pkg::SUM_W-1:0]  t_s2, u_s2;
	logic signed [rtmp_pkg::MUL_W-1:0]  tz_s3, uz_s3;

	logic signed [rtmp_pkg::POS_W-1:0]  px, py;
	logic [rtmp_pkg::LIM_W-1:0]         rows_lim, cols_lim, flip_row;
	cell_t                              cell_c, cell_r;
	logic signed [rtmp_pkg::SCR_W-1:0]  scol, srow;
	logic                               marker;
	logic                               write_ok;

	function automatic cell_t cell_of(logic signed [rtmp_pkg::POS_W-1:0] pos,
		logic [rtmp_pkg::LIM_W-1:0] lim);
		cell_t res;
		res.idx = '0;
		res.ok  = 1'b0;
		if (pos[rtmp_pkg::POS_W-1]) begin
			// Offsets just below zero truncate toward zero into cell 0.
			res.ok = (&pos[rtmp_pkg::POS_W-1:rtmp_pkg::CELL_SHIFT])
				&& (|pos[rtmp_pkg::CELL_SHIFT-1:0]) && (lim != '0);
		end else begin
			res.idx = pos[rtmp_pkg::POS_W-1:rtmp_pkg::CELL_SHIFT];
			res.ok  = (res.idx < rtmp_pkg::CIDX_W'(lim));
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= '0;
			player_y_q <= '0;
			dir_x_q    <= rtmp_pkg::DIR_X_RESET;
			dir_y_q    <= rtmp_pkg::DIR_Y_RESET;
			zoom_q     <= rtmp_pkg::ZOOM_RESET;
			map_rows_q <= rtmp_pkg::ROWS_RESET;
			map_cols_q <= rtmp_pkg::COLS_RESET;
		end else if (cfg_we) begin
			case (rtmp_pkg::cfg_idx_t'(cfg_addr))
				rtmp_pkg::CFG_PLAYER_X: player_x_q <= cfg_wdata;
				rtmp_pkg::CFG_PLAYER_Y: player_y_q <= cfg_wdata;
				rtmp_pkg::CFG_DIR_X:    dir_x_q    <= cfg_wdata[15:0];
				rtmp_pkg::CFG_DIR_Y:    dir_y_q    <= cfg_wdata[15:0];
				rtmp_pkg::CFG_ZOOM:     zoom_q     <= cfg_wdata[15:0];
				rtmp_pkg::CFG_MAP_ROWS: map_rows_q <= cfg_wdata[rtmp_pkg::LIM_W-1:0];
				rtmp_pkg::CFG_MAP_COLS: map_cols_q <= cfg_wdata[rtmp_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !(valid_s3 && q_full);
	assign in_ready = en;
	assign q_push   = valid_s3 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_data;
			ptx_s1  <= dir_x_q * $signed(in_data.pixel_y);
			pty_s1  <= dir_y_q * $signed(in_data.pixel_x);
			puy_s1  <= dir_y_q * $signed(in_data.pixel_y);
			pux_s1  <= dir_x_q * $signed(in_data.pixel_x);
			item_s2 <= item_s1;
			t_s2    <= rtmp_pkg::SUM_W'(ptx_s1) + rtmp_pkg::SUM_W'(pty_s1);
			u_s2    <= rtmp_pkg::SUM_W'(puy_s1) - rtmp_pkg::SUM_W'(pux_s1);
			item_s3 <= item_s2;
			tz_s3   <= t_s2 * $signed({1'b0, zoom_q});
			uz_s3   <= u_s2 * $signed({1'b0, zoom_q});
		end
	end

	always_comb begin
		px = rtmp_pkg::POS_W'(player_x_q)
			+ rtmp_pkg::POS_W'(tz_s3[rtmp_pkg::MUL_W-1:14]);
		py = rtmp_pkg::POS_W'(player_y_q)
			+ rtmp_pkg::POS_W'(uz_s3[rtmp_pkg::MUL_W-1:14]);
		rows_lim = (map_rows_q > rtmp_pkg::LIM_W'(rtmp_pkg::MAX_ROWS))
			? rtmp_pkg::LIM_W'(rtmp_pkg::MAX_ROWS) : map_rows_q;
		cols_lim = (map_cols_q > rtmp_pkg::LIM_W'(rtmp_pkg::MAX_COLS))
			? rtmp_pkg::LIM_W'(rtmp_pkg::MAX_COLS) : map_cols_q;
		cell_c   = cell_of(px, cols_lim);
		cell_r   = cell_of(py, rows_lim);
		flip_row = rows_lim - 1'b1 - cell_r.idx[rtmp_pkg::LIM_W-1:0];

		scol = rtmp_pkg::SCR_W'($signed(item_s3.pixel_x))
			+ rtmp_pkg::SCR_W'(rtmp_pkg::VIEW_HALF);
		srow = rtmp_pkg::SCR_W'(rtmp_pkg::VIEW_HALF - 1)
			- rtmp_pkg::SCR_W'($signed(item_s3.pixel_y));
		marker = (scol >= rtmp_pkg::SCR_W'(rtmp_pkg::MARK_LO))
			&& (scol < rtmp_pkg::SCR_W'(rtmp_pkg::MARK_HI))
			&& (srow >= rtmp_pkg::SCR_W'(rtmp_pkg::MARK_LO))
			&& (srow < rtmp_pkg::SCR_W'(rtmp_pkg::MARK_HI));

		write_ok = (32'(item_s3.cell_row) < rtmp_pkg::MAX_ROWS)
			&& (32'(item_s3.cell_col) < rtmp_pkg::MAX_COLS);

		q_data            = '0;
		q_data.is_pix     = (item_s3.req_type == rtmp_pkg::REQ_PIXEL);
		q_data.screen_col = scol[7:0];
		q_data.screen_row = srow[7:0];
		q_data.player_sq  = marker;
		q_data.wall       = item_s3.cell_wall;
		if (item_s3.req_type == rtmp_pkg::REQ_WRITE) begin
			q_data.in_map = write_ok;
			q_data.addr   = {item_s3.cell_row[rtmp_pkg::ROW_W-1:0],
				item_s3.cell_col[rtmp_pkg::COL_W-1:0]};
		end else begin
			q_data.in_map = cell_c.ok && cell_r.ok;
			q_data.addr   = {flip_row[rtmp_pkg::ROW_W-1:0],
				cell_c.idx[rtmp_pkg::COL_W-1:0]};
		end
	end

endmodule

>>> rtl/rtmp_back.sv
// Back end: wall map memory, map reads and writes, color choice and the output register.
module rtmp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  rtmp_pkg::q_entry_t  q_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rtmp_pkg::out_item_t out_data
);

	logic                 wall_mem [rtmp_pkg::MAP_DEPTH];
	logic                 valid_s4;
	rtmp_pkg::q_entry_t   entry_s4;
	logic                 wall_s4;
	logic                 out_valid_q;
	rtmp_pkg::out_item_t  out_data_q;
	logic                 adv_out;
	logic                 move_s4;
	logic [23:0]          color;

	assign adv_out   = !out_valid_q || out_ready;
	assign move_s4   = valid_s4 && adv_out;
	assign q_pop     = !q_empty && (!valid_s4 || move_s4);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (q_pop && !q_data.is_pix && q_data.in_map) begin
			wall_mem[q_data.addr] <= q_data.wall;
		end
		if (q_pop && q_data.is_pix) begin
			wall_s4  <= wall_mem[q_data.addr];
			entry_s4 <= q_data;
		end
	end

	always_comb begin
		if (entry_s4.player_sq) begin
			color = rtmp_pkg::COLOR_PLAYER;
		end else if (!entry_s4.in_map) begin
			color = rtmp_pkg::COLOR_OUT;
		end else if (wall_s4) begin
			color = rtmp_pkg::COLOR_WALL;
		end else begin
			color = rtmp_pkg::COLOR_FLOOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s4 <= q_data.is_pix;
			end else if (move_s4) begin
				valid_s4 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s4) begin
			out_data_q.screen_col <= entry_s4.screen_col;
			out_data_q.screen_row <= entry_s4.screen_row;
			out_data_q.color      <= color;
		end
	end

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && out_valid_q && !out_ready) |=> (valid_s4 && $stable(entry_s4)))
		else $error("map stage lost a pixel while the output stalled");

	a_pixel_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_data.is_pix) |=> valid_s4)
		else $error("popped pixel did not reach the map stage");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !q_data.is_pix) |=> !valid_s4)
		else $error("map write produced a pixel beat");

endmodule
